// ===== design/tgkm_pkg.sv =====
// Package for the touchpad gesture key mapper: command codes, key codes,
// gesture modes, event structs and shared helper functions. No dependencies.
package tgkm_pkg;

  localparam int COUNT_MAX = 15;
  localparam int CNT_W = $clog2(COUNT_MAX + 1);

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_UPDATE   = 3'd1,
    CMD_COMPLETE = 3'd2,
    CMD_CDOWN    = 3'd3,
    CMD_CUP      = 3'd4,
    CMD_PDOWN    = 3'd5,
    CMD_PUP      = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_SWITCH    = 2'd1,
    MODE_DESKTOP   = 2'd2
  } mode_t;

  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_D     = 8'h44;
  localparam logic [7:0] KEY_META  = 8'h5B;
  localparam logic [7:0] KEY_ALT   = 8'hA4;
  localparam logic [7:0] KEY_LEFT  = 8'h25;
  localparam logic [7:0] KEY_UP    = 8'h26;
  localparam logic [7:0] KEY_RIGHT = 8'h27;
  localparam logic [7:0] KEY_DOWN  = 8'h28;
  localparam logic [2:0] MOD_NONE  = 3'd0;
  localparam logic [2:0] MOD_ALT   = 3'd1;
  localparam logic [2:0] MOD_META  = 3'd4;

  localparam logic [2:0] ADDR_INIT_TH = 3'd0;
  localparam logic [2:0] ADDR_ACT_TH  = 3'd1;
  localparam logic [2:0] ADDR_STEP_H  = 3'd2;
  localparam logic [2:0] ADDR_STEP_V  = 3'd3;
  localparam logic [2:0] ADDR_DOM     = 3'd4;

  typedef struct packed {
    logic [14:0] initial_threshold;
    logic [14:0] action_threshold;
    logic [14:0] step_horizontal;
    logic [14:0] step_vertical;
    logic [9:0]  dominance_ratio;
  } cfg_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       key_down;
    logic [2:0] modifiers;
    logic       last;
  } key_ev_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        capture_active;
    logic [15:0] move_x;
    logic [15:0] move_y;
  } req_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_DIV_X,
    BS_DIV_Y,
    BS_DECIDE,
    BS_EMIT
  } bstate_t;

  function automatic key_ev_t mk_ev(logic [7:0] code, logic down, logic [2:0] mods);
    key_ev_t e;
    e.key_code = code;
    e.key_down = down;
    e.modifiers = mods;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic logic [15:0] abs16(logic [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

endpackage

// ===== design/touchpad_gesture_key_mapper_core.sv =====
// Top level of the touchpad gesture key mapper.
// Depends on tgkm_pkg, tgkm_front, tgkm_fifo and tgkm_back.
// Requests enter a two-entry queue and are executed one at a time. In the
// back end each request first runs two sequential divisions for the arrow
// step indices, then the decide state, then delivers its key events; up to
// four key events follow one request.
module touchpad_gesture_key_mapper_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic        capture_active,
  input  logic signed [15:0] move_x,
  input  logic signed [15:0] move_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  key_code,
  output logic        key_down,
  output logic [2:0]  modifiers,
  output logic        last
);
  import tgkm_pkg::*;

  cfg_t    cfg;
  req_t    q_wdata, q_rdata;
  logic    q_wr, q_full, q_empty, q_take;
  key_ev_t ev;

  tgkm_front u_front (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .capture_active(capture_active), .move_x(move_x), .move_y(move_y),
    .q_wr(q_wr), .q_data(q_wdata), .q_full(q_full)
  );

  tgkm_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_en(q_wr), .wr_data(q_wdata), .full(q_full),
    .rd_en(q_take), .rd_data(q_rdata), .empty(q_empty)
  );

  tgkm_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .req_valid(!q_empty), .req(q_rdata),
    .req_take(q_take), .ev_valid(out_valid), .ev(ev), .ev_stall(out_stall)
  );

  assign key_code = ev.key_code;
  assign key_down = ev.key_down;
  assign modifiers = ev.modifiers;
  assign last = ev.last;

endmodule

// ===== design/tgkm_div.sv =====
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tgkm_pkg.
module tgkm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [14:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import tgkm_pkg::*;

  logic [4:0]  cnt;
  logic        busy;
  logic        neg;
  logic [15:0] q;
  logic [15:0] rem;
  logic [14:0] dv;
  logic [16:0] trial;

  assign trial = {rem, q[15]} - {2'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'd16;
        neg <= dividend[15];
        q <= abs16(dividend);
        rem <= '0;
        dv <= (divisor == '0) ? 15'd1 : divisor;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial[15:0];
          q <= {q[14:0], 1'b1};
        end else begin
          rem <= {rem[14:0], q[15]};
          q <= {q[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 16'(-q) : q;

endmodule

// ===== design/tgkm_fifo.sv =====
// Short request queue between the front and the back of the key mapper.
// Depends on tgkm_pkg.
module tgkm_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  tgkm_pkg::req_t       wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output tgkm_pkg::req_t       rd_data,
  output logic                 empty
);
  import tgkm_pkg::*;

  req_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !wr_en)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !rd_en)
    else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ===== design/tgkm_back.sv =====
// Back end: executes one request at a time, updating gesture state and
// emitting up to four key events. Depends on tgkm_pkg and tgkm_div.
module tgkm_back (
  input  logic             clk,
  input  logic             rst,
  input  tgkm_pkg::cfg_t   cfg,
  input  logic             req_valid,
  input  tgkm_pkg::req_t   req,
  output logic             req_take,
  output logic             ev_valid,
  output tgkm_pkg::key_ev_t ev,
  input  logic             ev_stall
);
  import tgkm_pkg::*;

  bstate_t state, state_next;
  req_t    cur;
  mode_t   gesture_mode;
  logic    switch_held;
  logic [CNT_W-1:0] contact_count;
  logic [15:0] last_step_x, last_step_y;
  logic [15:0] sx, sy;
  key_ev_t evbuf [4];
  logic [2:0] nev, idx;

  logic        div_start, div_done;
  logic [15:0] div_in, div_q;
  logic [14:0] div_dv;
  logic        div_first;

  logic [15:0] ax, ay;
  logic [25:0] ax_s, ay_s, ax_r, ay_r;
  logic        horiz, vert, to_desktop, to_switch;

  assign ax = abs16(cur.move_x);
  assign ay = abs16(cur.move_y);
  assign ax_s = {ax, 8'd0} + 26'd0;
  assign ay_s = {ay, 8'd0} + 26'd0;
  assign ax_r = 26'(ax) * 26'(cfg.dominance_ratio);
  assign ay_r = 26'(ay) * 26'(cfg.dominance_ratio);
  assign horiz = ax_s > ay_r;
  assign vert = ay_s > ax_r;
  assign to_desktop = gesture_mode == MODE_UNDECIDED
                      && {1'b0, ay} >= {2'b0, cfg.action_threshold} && vert;
  assign to_switch = gesture_mode == MODE_UNDECIDED
                     && {1'b0, ax} >= {2'b0, cfg.initial_threshold} && horiz;

  tgkm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
    .divisor(div_dv), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE:   if (req_valid) state_next = BS_DIV_X;
      BS_DIV_X:  if (div_done) state_next = BS_DIV_Y;
      BS_DIV_Y:  if (div_done) state_next = BS_DECIDE;
      BS_DECIDE: state_next = BS_EMIT;
      BS_EMIT:   if (idx == nev || (!ev_stall && idx + 3'd1 == nev)) state_next = BS_IDLE;
      default:   state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    req_take = 1'b0;
    div_start = 1'b0;
    div_in = cur.move_x;
    div_dv = cfg.step_horizontal;
    unique case (state)
      BS_IDLE: req_take = req_valid;
      BS_DIV_X: div_start = div_first;
      BS_DIV_Y: begin
        div_start = div_first;
        div_in = cur.move_y;
        div_dv = to_switch ? cfg.step_horizontal : cfg.step_vertical;
      end
      default: ;
    endcase
  end

  assign ev_valid = state == BS_EMIT && idx != nev;
  always_comb begin
    ev = evbuf[idx[1:0]];
    ev.last = (idx + 3'd1 == nev);
  end

  // Decision logic for one request, evaluated in the decide state.
  mode_t   m_n;
  logic    h_n;
  logic [CNT_W-1:0] c_n;
  logic [15:0] lx_n, ly_n;
  key_ev_t e [4];
  logic [2:0] n_n;
  logic [16:0] dx, dy, adx, ady;

  always_comb begin
    m_n = gesture_mode;
    h_n = switch_held;
    c_n = contact_count;
    lx_n = last_step_x;
    ly_n = last_step_y;
    n_n = 3'd0;
    for (int i = 0; i < 4; i++) e[i] = mk_ev(8'd0, 1'b0, MOD_NONE);
    dx = {sx[15], sx} - {last_step_x[15], last_step_x};
    dy = {sy[15], sy} - {last_step_y[15], last_step_y};
    adx = dx[16] ? 17'(-dx) : dx;
    ady = dy[16] ? 17'(-dy) : dy;
    if (cur.cmd != CMD_NONE) begin
      if (!cur.capture_active) begin
        if (switch_held) begin e[0] = mk_ev(KEY_ALT, 1'b0, MOD_NONE); n_n = 3'd1; end
        h_n = 1'b0; m_n = MODE_UNDECIDED; c_n = '0; lx_n = '0; ly_n = '0;
      end else begin
        case (cur.cmd)
          CMD_START: begin
            if (switch_held) begin e[0] = mk_ev(KEY_ALT, 1'b0, MOD_NONE); n_n = 3'd1; end
            h_n = 1'b0; m_n = MODE_UNDECIDED; lx_n = '0; ly_n = '0;
          end
          CMD_UPDATE: begin
            if (gesture_mode == MODE_DESKTOP) begin
            end else if (to_desktop) begin
              m_n = MODE_DESKTOP;
            end else if (to_switch) begin
              m_n = MODE_SWITCH;
              if (!switch_held) begin
                e[0] = mk_ev(KEY_ALT, 1'b1, MOD_ALT);
                e[1] = mk_ev(KEY_TAB, 1'b1, MOD_ALT);
                e[2] = mk_ev(KEY_TAB, 1'b0, MOD_ALT);
                n_n = 3'd3;
              end else begin
                e[0] = mk_ev(KEY_TAB, 1'b1, MOD_ALT);
                e[1] = mk_ev(KEY_TAB, 1'b0, MOD_ALT);
                n_n = 3'd2;
              end
              h_n = 1'b1; lx_n = sx; ly_n = sy;
            end else if (gesture_mode == MODE_SWITCH) begin
              if (adx >= ady && dx != '0) begin
                if (switch_held) begin
                  e[0] = mk_ev(dx[16] ? KEY_LEFT : KEY_RIGHT, 1'b1, MOD_ALT);
                  e[1] = mk_ev(dx[16] ? KEY_LEFT : KEY_RIGHT, 1'b0, MOD_ALT);
                  n_n = 3'd2;
                end
                lx_n = dx[16] ? last_step_x - 16'd1 : last_step_x + 16'd1;
              end else if (dy != '0) begin
                if (switch_held) begin
                  e[0] = mk_ev(dy[16] ? KEY_UP : KEY_DOWN, 1'b1, MOD_ALT);
                  e[1] = mk_ev(dy[16] ? KEY_UP : KEY_DOWN, 1'b0, MOD_ALT);
                  n_n = 3'd2;
                end
                ly_n = dy[16] ? last_step_y - 16'd1 : last_step_y + 16'd1;
              end
            end
          end
          CMD_COMPLETE: begin
            if (gesture_mode == MODE_SWITCH) begin
              if (switch_held) begin e[0] = mk_ev(KEY_ALT, 1'b0, MOD_NONE); n_n = 3'd1; end
            end else if (gesture_mode == MODE_DESKTOP
                         || (vert && {1'b0, ay} >= {2'b0, cfg.action_threshold})) begin
              e[0] = mk_ev(KEY_META, 1'b1, MOD_META);
              e[1] = mk_ev(KEY_D, 1'b1, MOD_META);
              e[2] = mk_ev(KEY_D, 1'b0, MOD_META);
              e[3] = mk_ev(KEY_META, 1'b0, MOD_NONE);
              n_n = 3'd4;
            end else if (horiz && {1'b0, ax} >= {2'b0, cfg.action_threshold}) begin
              if (!switch_held) begin
                e[0] = mk_ev(KEY_ALT, 1'b1, MOD_ALT);
                e[1] = mk_ev(KEY_TAB, 1'b1, MOD_ALT);
                e[2] = mk_ev(KEY_TAB, 1'b0, MOD_ALT);
                e[3] = mk_ev(KEY_ALT, 1'b0, MOD_NONE);
                n_n = 3'd4;
              end else begin
                e[0] = mk_ev(KEY_TAB, 1'b1, MOD_ALT);
                e[1] = mk_ev(KEY_TAB, 1'b0, MOD_ALT);
                e[2] = mk_ev(KEY_ALT, 1'b0, MOD_NONE);
                n_n = 3'd3;
              end
            end
            h_n = 1'b0; m_n = MODE_UNDECIDED; c_n = '0; lx_n = '0; ly_n = '0;
          end
          CMD_CDOWN: if (contact_count != CNT_W'(COUNT_MAX)) c_n = contact_count + 1'b1;
          CMD_CUP: begin
            if (contact_count != '0) c_n = contact_count - 1'b1;
            if (c_n == '0 && switch_held) begin
              e[0] = mk_ev(KEY_ALT, 1'b0, MOD_NONE); n_n = 3'd1; h_n = 1'b0;
            end
          end
          CMD_PDOWN: c_n = CNT_W'(3);
          CMD_PUP: if (contact_count == '0 && switch_held) begin
            e[0] = mk_ev(KEY_ALT, 1'b0, MOD_NONE); n_n = 3'd1; h_n = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) cur <= req;
    if (div_done && state == BS_DIV_X) sx <= div_q;
    if (div_done && state == BS_DIV_Y) sy <= div_q;
    if (state == BS_DECIDE) for (int i = 0; i < 4; i++) evbuf[i] <= e[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      gesture_mode <= MODE_UNDECIDED;
      switch_held <= 1'b0;
      contact_count <= '0;
      last_step_x <= '0;
      last_step_y <= '0;
      nev <= '0;
      idx <= '0;
      div_first <= 1'b0;
    end else begin
      state <= state_next;
      div_first <= (state == BS_IDLE && req_valid) || (state == BS_DIV_X && div_done);
      if (state == BS_DECIDE) begin
        gesture_mode <= m_n;
        switch_held <= h_n;
        contact_count <= c_n;
        last_step_x <= lx_n;
        last_step_y <= ly_n;
        nev <= n_n;
        idx <= '0;
      end else if (ev_valid && !ev_stall) begin
        idx <= idx + 3'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_ev_bound: assert property (@(posedge clk) disable iff (rst) nev <= 3'd4)
    else $error("too many key events");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst) idx <= nev || state != BS_EMIT)
    else $error("event index past count");
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    contact_count <= CNT_W'(COUNT_MAX))
    else $error("contact count beyond limit");
  a_held_mode: assert property (@(posedge clk) disable iff (rst)
    switch_held |-> gesture_mode == MODE_SWITCH)
    else $error("alt held outside window switch");
`endif

endmodule

// ===== design/tgkm_front.sv =====
// Front end: configuration registers over APB and request intake into the queue.
// Depends on tgkm_pkg.
module tgkm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tgkm_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        cmd,
  input  logic              capture_active,
  input  logic [15:0]       move_x,
  input  logic [15:0]       move_y,
  output logic              q_wr,
  output tgkm_pkg::req_t    q_data,
  input  logic              q_full
);
  import tgkm_pkg::*;

  logic [2:0] ra;
  assign ra = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_threshold <= 15'd560;
      cfg.action_threshold <= 15'd1120;
      cfg.step_horizontal <= 15'd720;
      cfg.step_vertical <= 15'd1440;
      cfg.dominance_ratio <= 10'd346;
    end else if (psel && penable && pwrite) begin
      case (ra)
        ADDR_INIT_TH: cfg.initial_threshold <= pwdata[14:0];
        ADDR_ACT_TH:  cfg.action_threshold <= pwdata[14:0];
        ADDR_STEP_H:  cfg.step_horizontal <= pwdata[14:0];
        ADDR_STEP_V:  cfg.step_vertical <= pwdata[14:0];
        ADDR_DOM:     cfg.dominance_ratio <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ra)
      ADDR_INIT_TH: prdata = {17'd0, cfg.initial_threshold};
      ADDR_ACT_TH:  prdata = {17'd0, cfg.action_threshold};
      ADDR_STEP_H:  prdata = {17'd0, cfg.step_horizontal};
      ADDR_STEP_V:  prdata = {17'd0, cfg.step_vertical};
      ADDR_DOM:     prdata = {22'd0, cfg.dominance_ratio};
      default:      prdata = '0;
    endcase
  end

  // Requests with CMD_NONE are dropped here and never reach the back end.
  assign in_stall = q_full;
  assign q_wr = in_valid && !q_full && cmd != CMD_NONE;
  assign q_data = '{cmd: cmd, capture_active: capture_active, move_x: move_x, move_y: move_y};

endmodule

// ===== sim/touchpad_gesture_key_mapper_core_tb.sv =====
// Self-checking testbench for touchpad_gesture_key_mapper_core.
// Depends on tgkm_pkg and the core; drives gesture requests, predicts the key
// events in a behavioral model and compares them with what the core delivers.
module touchpad_gesture_key_mapper_core_tb;
  import tgkm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = CMD_START;
  logic capture_active = 1'b0;
  logic signed [15:0] move_x = '0, move_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] key_code;
  logic key_down;
  logic [2:0] modifiers;
  logic last;

  touchpad_gesture_key_mapper_core DUT (.*);

  always #4 clk = ~clk;

  typedef struct {
    logic [2:0] c;
    logic act;
    int x;
    int y;
    int nexp;
    key_ev_t ev0;
  } row_t;

  // Behavioral copy of the mapper's settings and state.
  int th_init, th_act, st_h, st_v, dom;
  mode_t g_mode;
  bit alt_held;
  int contacts, pos_x, pos_y;
  key_ev_t key_events[$];
  key_ev_t batch[$];

  int errors = 0;
  int n_req = 0, n_keys = 0;
  int sender_idle = 0, receiver_busy = 0;
  int hold_off = 0;
  int quiet = 0;

  function automatic void put_key(logic [7:0] c, logic d, logic [2:0] m);
    key_ev_t e;
    e.key_code = c; e.key_down = d; e.modifiers = m; e.last = 1'b0;
    if (batch.size() < 4) batch.push_back(e);
  endfunction

  function automatic void tab_step();
    if (!alt_held) begin
      put_key(KEY_ALT, 1'b1, MOD_ALT);
      alt_held = 1'b1;
    end
    put_key(KEY_TAB, 1'b1, MOD_ALT);
    put_key(KEY_TAB, 1'b0, MOD_ALT);
  endfunction

  function automatic void drop_alt();
    if (alt_held) begin
      put_key(KEY_ALT, 1'b0, MOD_NONE);
      alt_held = 1'b0;
    end
  endfunction

  function automatic bit over(int a, int b);
    return longint'(a) * 256 > longint'(b) * dom;
  endfunction

  function automatic int step_div(int v, int s);
    return v / (s == 0 ? 1 : s);
  endfunction

  function automatic void wipe();
    drop_alt();
    g_mode = MODE_UNDECIDED;
    contacts = 0; pos_x = 0; pos_y = 0;
  endfunction

  function automatic void map_gesture(logic [2:0] c, logic act, int x, int y);
    int ax, ay, sx, sy, dx, dy;
    batch.delete();
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    if (c == CMD_NONE) return;
    if (!act) wipe();
    else case (c)
      CMD_START: begin
        drop_alt();
        g_mode = MODE_UNDECIDED; pos_x = 0; pos_y = 0;
      end
      CMD_UPDATE: begin
        if (g_mode == MODE_UNDECIDED && ay >= th_act && over(ay, ax)) begin
          g_mode = MODE_DESKTOP;
        end else if (g_mode == MODE_UNDECIDED && ax >= th_init && over(ax, ay)) begin
          g_mode = MODE_SWITCH;
          tab_step();
          pos_x = step_div(x, st_h);
          pos_y = step_div(y, st_h);
        end else if (g_mode == MODE_SWITCH) begin
          sx = step_div(x, st_h);
          sy = step_div(y, st_v);
          dx = sx - pos_x;
          dy = sy - pos_y;
          if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy) && dx != 0) begin
            if (alt_held) begin
              put_key(dx > 0 ? KEY_RIGHT : KEY_LEFT, 1'b1, MOD_ALT);
              put_key(dx > 0 ? KEY_RIGHT : KEY_LEFT, 1'b0, MOD_ALT);
            end
            pos_x += dx > 0 ? 1 : -1;
          end else if (dy != 0) begin
            if (alt_held) begin
              put_key(dy > 0 ? KEY_DOWN : KEY_UP, 1'b1, MOD_ALT);
              put_key(dy > 0 ? KEY_DOWN : KEY_UP, 1'b0, MOD_ALT);
            end
            pos_y += dy > 0 ? 1 : -1;
          end
        end
      end
      CMD_COMPLETE: begin
        if (g_mode == MODE_SWITCH) drop_alt();
        else if (g_mode == MODE_DESKTOP || (over(ay, ax) && ay >= th_act)) begin
          put_key(KEY_META, 1'b1, MOD_META);
          put_key(KEY_D, 1'b1, MOD_META);
          put_key(KEY_D, 1'b0, MOD_META);
          put_key(KEY_META, 1'b0, MOD_NONE);
        end else if (over(ax, ay) && ax >= th_act) begin
          tab_step();
          drop_alt();
        end
        wipe();
      end
      CMD_CDOWN: if (contacts < COUNT_MAX) contacts++;
      CMD_CUP: begin
        if (contacts > 0) contacts--;
        if (contacts == 0) drop_alt();
      end
      CMD_PDOWN: contacts = 3;
      default: if (contacts == 0) drop_alt();
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endfunction

  function automatic void set_reg(int idx, int v);
    case (idx)
      ADDR_INIT_TH: th_init = v & 16'h7fff;
      ADDR_ACT_TH:  th_act = v & 16'h7fff;
      ADDR_STEP_H:  st_h = v & 16'h7fff;
      ADDR_STEP_V:  st_v = v & 16'h7fff;
      default:      dom = v & 10'h3ff;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, int v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    set_reg(idx, v);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (key_events.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Sends one request, predicts it, optionally checks the predicted events.
  task automatic send(logic [2:0] c, logic act, int x, int y, int nexp, key_ev_t ev0);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; cmd <= c; capture_active <= act; move_x <= 16'(x); move_y <= 16'(y);
    do @(posedge clk); while (in_stall);
    map_gesture(c, act, x, y);
    if (nexp >= 0 && (batch.size() != nexp || (nexp > 0 && batch[0] != ev0))) begin
      $display("%0t table row mismatch: expected %0d events first %h, predicted %0d first %h",
               $time, nexp, ev0, batch.size(), batch.size() ? batch[0] : '0);
      errors++;
    end
    foreach (batch[i]) key_events.push_back(batch[i]);
    n_req++;
    @(negedge clk);
  endtask

  function automatic int rnd_move();
    case ($urandom_range(5))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(1) ? 32767 : -32768;
      default: return int'($urandom_range(6000)) - 3000;
    endcase
  endfunction

  function automatic logic [2:0] rnd_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 45) return CMD_UPDATE;
    if (r < 55) return CMD_START;
    if (r < 65) return CMD_COMPLETE;
    if (r < 95) return 3'(3 + $urandom_range(3));
    return CMD_NONE;
  endfunction

  // Result check and receiver stalls.
  always @(posedge clk) begin
    key_ev_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.key_code = key_code; got.key_down = key_down;
      got.modifiers = modifiers; got.last = last;
      n_keys++;
      if (key_events.size() == 0) begin
        $display("%0t unexpected key event %h", $time, got);
        errors++;
      end else begin
        want = key_events.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected code %h down %b mods %h last %b, got %h %b %h %b",
                   $time, want.key_code, want.key_down, want.modifiers, want.last,
                   got.key_code, got.key_down, got.modifiers, got.last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_busy > 0 && $urandom_range(99) < receiver_busy;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("** touchpad_gesture_key_mapper_core: FAILED **");
      $finish;
    end
  end

  row_t rows[$];
  key_ev_t alt_dn, meta_dn, alt_up, none_ev;

  initial begin
    int ph;
    set_reg(ADDR_INIT_TH, 560); set_reg(ADDR_ACT_TH, 1120);
    set_reg(ADDR_STEP_H, 720); set_reg(ADDR_STEP_V, 1440); set_reg(ADDR_DOM, 346);
    g_mode = MODE_UNDECIDED; alt_held = 0; contacts = 0; pos_x = 0; pos_y = 0;
    alt_dn = mk_ev(KEY_ALT, 1'b1, MOD_ALT);
    meta_dn = mk_ev(KEY_META, 1'b1, MOD_META);
    alt_up = mk_ev(KEY_ALT, 1'b0, MOD_NONE); alt_up.last = 1'b1;
    none_ev = '0;
    rows = '{
      '{CMD_UPDATE, 1, 0, 0, 0, none_ev},
      '{CMD_UPDATE, 1, 800, 0, 3, alt_dn},
      '{CMD_UPDATE, 1, 2000, 0, -1, none_ev},
      '{CMD_UPDATE, 1, 2000, 3000, -1, none_ev},
      '{CMD_UPDATE, 1, -32768, 32767, -1, none_ev},
      '{CMD_START, 1, 0, 0, 1, alt_up},
      '{CMD_UPDATE, 1, -900, 0, 3, alt_dn},
      '{CMD_COMPLETE, 1, 0, 0, 1, alt_up},
      '{CMD_UPDATE, 1, 0, -2000, 0, none_ev},
      '{CMD_COMPLETE, 1, 0, 0, 4, meta_dn},
      '{CMD_COMPLETE, 1, 0, 32767, 4, meta_dn},
      '{CMD_COMPLETE, 1, -32768, 0, -1, none_ev},
      '{CMD_COMPLETE, 1, 100, 100, 0, none_ev},
      '{CMD_PDOWN, 1, 0, 0, 0, none_ev},
      '{CMD_UPDATE, 1, 32767, 0, 3, alt_dn},
      '{CMD_CUP, 1, 0, 0, 0, none_ev},
      '{CMD_CUP, 1, 0, 0, 0, none_ev},
      '{CMD_CUP, 1, 0, 0, 1, alt_up},
      '{CMD_START, 1, 0, 0, 0, none_ev},
      '{CMD_UPDATE, 1, 900, 0, 3, alt_dn},
      '{CMD_PUP, 1, 0, 0, 1, alt_up},
      '{CMD_START, 1, 0, 0, 0, none_ev},
      '{CMD_UPDATE, 1, 900, 0, 3, alt_dn},
      '{CMD_NONE, 0, 0, 0, 0, none_ev},
      '{CMD_CDOWN, 0, -1, -1, 1, alt_up}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send(rows[i].c, rows[i].act, rows[i].x, rows[i].y,
                           rows[i].nexp, rows[i].ev0);
    repeat (17) send(CMD_CDOWN, 1, 0, 0, 0, none_ev);
    settle();
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin sender_idle = 0; receiver_busy = 0; end
        1: begin sender_idle = 77; receiver_busy = 0; end
        2: begin sender_idle = 0; receiver_busy = 77; end
        3: begin sender_idle = 37; receiver_busy = 37; end
        default: begin sender_idle = 0; receiver_busy = 0; end
      endcase
      if (ph == 1) begin
        write_reg(ADDR_INIT_TH, 0); write_reg(ADDR_ACT_TH, 32767);
        write_reg(ADDR_STEP_H, 0); write_reg(ADDR_STEP_V, 1); write_reg(ADDR_DOM, 256);
      end else if (ph == 2) begin
        write_reg(ADDR_INIT_TH, 32767); write_reg(ADDR_ACT_TH, 0);
        write_reg(ADDR_STEP_H, 32767); write_reg(ADDR_STEP_V, 32767);
        write_reg(ADDR_DOM, 1023);
      end else if (ph >= 3) begin
        write_reg(ADDR_INIT_TH, $urandom_range(1500)); write_reg(ADDR_ACT_TH,
          $urandom_range(3000)); write_reg(ADDR_STEP_H, $urandom_range(1, 800));
        write_reg(ADDR_STEP_V, $urandom_range(1, 800));
        write_reg(ADDR_DOM, $urandom_range(256, 1023));
      end
      if (ph == 4) hold_off = 400;
      repeat (4) begin
        if ($urandom_range(3) == 0) send(rnd_cmd(), $urandom_range(9) != 0,
                                         rnd_move(), rnd_move(), -1, none_ev);
        else begin
          int k, n, gx, gy;
          send(CMD_PDOWN, 1, 0, 0, -1, none_ev);
          send(CMD_START, 1, 0, 0, -1, none_ev);
          n = $urandom_range(2, 5); gx = 0; gy = 0;
          for (k = 0; k < n; k++) begin
            gx += int'($urandom_range(1200)) - 400;
            gy += int'($urandom_range(1200)) - 600;
            send(CMD_UPDATE, 1, gx, gy, -1, none_ev);
          end
          send($urandom_range(1) ? CMD_COMPLETE : CMD_CUP, 1, gx, gy, -1, none_ev);
        end
      end
      settle();
    end
    $display("Sent %0d requests over five settings and idle mixes; %0d key events checked.",
             n_req, n_keys);
    if (errors == 0 && key_events.size() == 0)
      $display("** touchpad_gesture_key_mapper_core: PASSED **");
    else
      $display("** touchpad_gesture_key_mapper_core: FAILED **");
    $finish;
  end
endmodule
